>>> rtl/core/grid_wall_mapper_assert.svh
// Assertion macros shared by the wall mapper RTL.
`ifndef GRID_WALL_MAPPER_ASSERT_SVH
`define GRID_WALL_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define GWM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid_wall_mapper: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define GWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid_wall_mapper: next-cycle check failed");

`endif

>>> rtl/core/gwm_pkg.sv
package gwm_pkg;

   // Request codes carried on req_type.
   localparam logic [2:0] REQ_ADVANCE     = 3'd0;
   localparam logic [2:0] REQ_TURN_LEFT   = 3'd1;
   localparam logic [2:0] REQ_TURN_RIGHT  = 3'd2;
   localparam logic [2:0] REQ_TURN_AROUND = 3'd3;
   localparam logic [2:0] REQ_READ_CELL   = 3'd4;

   // Headings.
   localparam logic [1:0] HEAD_NORTH = 2'd0;
   localparam logic [1:0] HEAD_EAST  = 2'd1;
   localparam logic [1:0] HEAD_SOUTH = 2'd2;
   localparam logic [1:0] HEAD_WEST  = 2'd3;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_THRESHOLD = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_THRESHOLD  = 4'd1;

   localparam int unsigned DIST_W     = 16;
   localparam int unsigned MASK_W     = 4;
   localparam int unsigned RSP_POS_W  = 5;
   localparam int unsigned SELECT_W   = 5;

   localparam logic [DIST_W-1:0] FRONT_THRESHOLD_RESET = 16'd1500;
   localparam logic [DIST_W-1:0] SIDE_THRESHOLD_RESET  = 16'd120;

   // The start cell has its south and east walls known after reset.
   localparam logic [MASK_W-1:0] CELL0_RESET = 4'd6;

   typedef struct packed {
      logic off_grid;
      logic map_write;
      logic in_range;
   } nav_flags_type;

   // Wall bit for a heading: north bit 3, east bit 2, south bit 1, west bit 0.
   function automatic logic [MASK_W-1:0] wall_bit(input logic [1:0] dir);
      return 4'b1000 >> dir;
   endfunction

endpackage

>>> rtl/core/gwm_ram.sv
module gwm_ram #(
   parameter int unsigned WIDTH = 4,
   parameter int unsigned DEPTH = 25
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gwm_cell_store.sv
module gwm_cell_store #(
   parameter int unsigned DEPTH = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [gwm_pkg::MASK_W-1:0]    rd_mask,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [gwm_pkg::MASK_W-1:0]    wr_data
);

   import gwm_pkg::*;

   localparam int unsigned ADDR_W = $clog2(DEPTH);

   logic [MASK_W-1:0] ram_rd_data;
   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic              rd_valid_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [MASK_W-1:0] fwd_data_ff;

   gwm_ram #(
      .WIDTH (MASK_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // A cell never written reads as its reset mask.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
         rd_addr_ff  <= rd_addr;
      end
      if (wr_en) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   // The last write may land on the edge of the read, so it takes priority.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) begin
         rd_mask = fwd_data_ff;
      end else if (rd_valid_ff) begin
         rd_mask = ram_rd_data;
      end else if (rd_addr_ff == '0) begin
         rd_mask = CELL0_RESET;
      end else begin
         rd_mask = '0;
      end
   end

endmodule

>>> rtl/core/gwm_nav.sv
module gwm_nav #(
   parameter int unsigned GRID_SIDE = 5
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       step,
   input  logic [2:0]                                 req_type,
   input  logic [gwm_pkg::DIST_W-1:0]                 front_distance,
   input  logic [gwm_pkg::DIST_W-1:0]                 left_distance,
   input  logic [gwm_pkg::DIST_W-1:0]                 right_distance,
   input  logic [gwm_pkg::SELECT_W-1:0]               cell_select,
   input  logic [gwm_pkg::DIST_W-1:0]                 front_threshold,
   input  logic [gwm_pkg::DIST_W-1:0]                 side_threshold,
   output logic [1:0]                                 heading_out,
   output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]     position_out,
   output logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0]     map_addr,
   output logic [gwm_pkg::MASK_W-1:0]                 sense_mask,
   output gwm_pkg::nav_flags_type                     flags
);

   import gwm_pkg::*;

   localparam int unsigned CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int unsigned CELL_AW    = $clog2(CELL_COUNT);
   localparam int unsigned CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int unsigned SUM_W      = CNT_W + 1;
   localparam int unsigned SEL_W      = (CNT_W > SELECT_W) ? CNT_W : SELECT_W;

   logic [1:0]         heading_ff, heading_in;
   logic [CELL_AW-1:0] position_ff, position_in;
   logic [SUM_W-1:0]   pos_ext, adv_sum;
   logic               adv_ok;
   logic [SEL_W-1:0]   sel_ext;
   logic               sel_in_range;
   logic [MASK_W-1:0]  sense_all;

   assign pos_ext = SUM_W'(position_ff);

   // Target cell of an advance along the current heading.
   always_comb begin
      case (heading_ff)
         HEAD_NORTH: begin
            adv_sum = pos_ext + SUM_W'(GRID_SIDE);
            adv_ok  = adv_sum < SUM_W'(CELL_COUNT);
         end
         HEAD_EAST: begin
            adv_sum = pos_ext + SUM_W'(1);
            adv_ok  = adv_sum < SUM_W'(CELL_COUNT);
         end
         HEAD_SOUTH: begin
            adv_sum = pos_ext - SUM_W'(GRID_SIDE);
            adv_ok  = pos_ext >= SUM_W'(GRID_SIDE);
         end
         default: begin
            adv_sum = pos_ext - SUM_W'(1);
            adv_ok  = pos_ext != '0;
         end
      endcase
   end

   assign sel_ext      = SEL_W'(cell_select);
   assign sel_in_range = sel_ext < SEL_W'(CELL_COUNT);

   // Side walls are rotated by the heading.
   always_comb begin
      sense_all = '0;
      if (front_distance < front_threshold) begin
         sense_all = sense_all | wall_bit(heading_ff);
      end
      if (left_distance < side_threshold) begin
         sense_all = sense_all | wall_bit(heading_ff + 2'd3);
      end
      if (right_distance < side_threshold) begin
         sense_all = sense_all | wall_bit(heading_ff + 2'd1);
      end
   end

   always_comb begin
      heading_out     = heading_ff;
      position_out    = position_ff;
      map_addr        = position_ff;
      sense_mask      = '0;
      flags.off_grid  = 1'b0;
      flags.map_write = 1'b0;
      flags.in_range  = 1'b1;
      case (req_type)
         REQ_ADVANCE: begin
            if (adv_ok) begin
               position_out    = adv_sum[CELL_AW-1:0];
               map_addr        = adv_sum[CELL_AW-1:0];
               sense_mask      = sense_all;
               flags.map_write = 1'b1;
            end else begin
               flags.off_grid = 1'b1;
            end
         end
         REQ_TURN_LEFT: begin
            heading_out = heading_ff + 2'd3;
         end
         REQ_TURN_RIGHT: begin
            heading_out = heading_ff + 2'd1;
         end
         REQ_TURN_AROUND: begin
            heading_out = heading_ff + 2'd2;
         end
         REQ_READ_CELL: begin
            map_addr       = sel_ext[CELL_AW-1:0];
            flags.in_range = sel_in_range;
         end
         default: begin
            heading_out = heading_ff;
         end
      endcase
   end

   assign heading_in  = step ? heading_out : heading_ff;
   assign position_in = step ? position_out : position_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff  <= HEAD_NORTH;
         position_ff <= '0;
      end else begin
         heading_ff  <= heading_in;
         position_ff <= position_in;
      end
   end

endmodule

>>> rtl/core/grid_wall_mapper.sv
// Wall mapper for a robot driving a square maze of GRID_SIDE x GRID_SIDE cells.
// Request words on req_* advance the robot one cell along its heading (sensing
// walls from the three distance readings), turn it left, right or around, or
// read back the wall mask of one cell. Each request word gives exactly one
// response word on rsp_* with the heading, position and cell mask afterwards.
// Threshold registers are written on csr_*, which is always ready; write them
// only while no request is in flight.
// An accepted word passes through the map stage register and then the output
// register; one word can be accepted every cycle while the output is not stalled.
// The map stage serves the registered read of the map RAM: a word reads its cell
// on acceptance and writes it back as it leaves the map stage, with a forwarding
// register covering a read of the cell just written.
// Reset returns the heading to north and the position to cell 0, and clears the
// map at once through per-cell valid bits (cell 0 reads with its south and east
// walls set), so no clearing pass is needed and req_ready is high right after.
// When the receiver stalls, the response word holds in the output register and
// one further word may still be taken into the map stage; after that req_ready
// falls until the output drains.
`include "grid_wall_mapper_assert.svh"

module grid_wall_mapper #(
   parameter int unsigned GRID_SIDE = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [gwm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [gwm_pkg::DIST_W-1:0]            csr_wdata,
   // Request channel
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_type,
   input  logic [gwm_pkg::DIST_W-1:0]            req_front_distance,
   input  logic [gwm_pkg::DIST_W-1:0]            req_left_distance,
   input  logic [gwm_pkg::DIST_W-1:0]            req_right_distance,
   input  logic [gwm_pkg::SELECT_W-1:0]          req_cell_select,
   // Response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_heading,
   output logic [gwm_pkg::RSP_POS_W-1:0]         rsp_position,
   output logic [gwm_pkg::MASK_W-1:0]            rsp_cell_walls,
   output logic                                  rsp_off_grid
);

   import gwm_pkg::*;

   localparam int unsigned CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int unsigned CELL_AW    = $clog2(CELL_COUNT);
   localparam int unsigned POS_W      = (CELL_AW > RSP_POS_W) ? CELL_AW : RSP_POS_W;

   // Threshold registers.
   logic [DIST_W-1:0] front_threshold_ff, front_threshold_in;
   logic [DIST_W-1:0] side_threshold_ff, side_threshold_in;

   // Handshake and pipeline control.
   logic req_accept;
   logic out_free;
   logic s1_move;

   // Navigation results for the word being accepted.
   logic [1:0]         nav_heading;
   logic [CELL_AW-1:0] nav_position;
   logic [CELL_AW-1:0] nav_addr;
   logic [MASK_W-1:0]  nav_sense;
   nav_flags_type      nav_flags;

   // Map stage: the word waits here for its cell mask from the RAM.
   logic               s1_valid_ff, s1_valid_in;
   logic [1:0]         s1_heading_ff;
   logic [CELL_AW-1:0] s1_position_ff;
   logic [CELL_AW-1:0] s1_addr_ff;
   logic [MASK_W-1:0]  s1_sense_ff;
   nav_flags_type      s1_flags_ff;
   logic [MASK_W-1:0]  store_mask;
   logic [MASK_W-1:0]  cell_mask;
   logic [POS_W-1:0]   s1_pos_wide;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_heading_ff;
   logic [RSP_POS_W-1:0] rsp_position_ff;
   logic [MASK_W-1:0]    rsp_cell_walls_ff;
   logic                 rsp_off_grid_ff;

   // Configuration writes are always taken; an unknown index is ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      front_threshold_in = front_threshold_ff;
      side_threshold_in  = side_threshold_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FRONT_THRESHOLD: front_threshold_in = csr_wdata;
            CSR_SIDE_THRESHOLD:  side_threshold_in  = csr_wdata;
            default:             front_threshold_in = front_threshold_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_threshold_ff <= FRONT_THRESHOLD_RESET;
         side_threshold_ff  <= SIDE_THRESHOLD_RESET;
      end else begin
         front_threshold_ff <= front_threshold_in;
         side_threshold_ff  <= side_threshold_in;
      end
   end

   // The map stage advances whenever the output register is empty or being
   // drained, and a new word may enter whenever the map stage will be free.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign req_accept = req_valid && req_ready;

   // Heading and position are updated as the word is accepted, so the next
   // word already sees them; only the map lags by one stage.
   gwm_nav #(
      .GRID_SIDE (GRID_SIDE)
   ) u_nav (
      .clock           (clock),
      .reset           (reset),
      .step            (req_accept),
      .req_type        (req_type),
      .front_distance  (req_front_distance),
      .left_distance   (req_left_distance),
      .right_distance  (req_right_distance),
      .cell_select     (req_cell_select),
      .front_threshold (front_threshold_ff),
      .side_threshold  (side_threshold_ff),
      .heading_out     (nav_heading),
      .position_out    (nav_position),
      .map_addr        (nav_addr),
      .sense_mask      (nav_sense),
      .flags           (nav_flags)
   );

   // The cell read is issued on acceptance; the updated mask is written back
   // as the word leaves the map stage.
   gwm_cell_store #(
      .DEPTH (CELL_COUNT)
   ) u_cell_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (nav_addr),
      .rd_mask (store_mask),
      .wr_en   (s1_move && s1_flags_ff.map_write),
      .wr_addr (s1_addr_ff),
      .wr_data (cell_mask)
   );

   // Sensed walls are only non-zero on an advance that was made. A read of a
   // cell beyond the grid reports an empty mask.
   assign cell_mask   = s1_flags_ff.in_range ? (store_mask | s1_sense_ff) : '0;
   assign s1_pos_wide = POS_W'(s1_position_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         s1_heading_ff  <= nav_heading;
         s1_position_ff <= nav_position;
         s1_addr_ff     <= nav_addr;
         s1_sense_ff    <= nav_sense;
         s1_flags_ff    <= nav_flags;
      end
      if (s1_move) begin
         rsp_heading_ff    <= s1_heading_ff;
         rsp_position_ff   <= s1_pos_wide[RSP_POS_W-1:0];
         rsp_cell_walls_ff <= cell_mask;
         rsp_off_grid_ff   <= s1_flags_ff.off_grid;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_heading    = rsp_heading_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_cell_walls = rsp_cell_walls_ff;
   assign rsp_off_grid   = rsp_off_grid_ff;

   // With both stages full and the receiver stalled, no word may enter.
   `GWM_ASSERT_IMPLY(a_full_stall_blocks, clock, reset,
      s1_valid_ff && rsp_valid_ff && !rsp_ready, !req_ready)
   // An accepted word always lands in the map stage.
   `GWM_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, s1_valid_ff)
   // A word held in the map stage keeps its cell address, so the RAM read
   // data and the write-back stay consistent across a stall.
   `GWM_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !out_free,
      s1_valid_ff && $stable(s1_addr_ff))

endmodule
